// ===== hdl/fh64_pkg.sv =====
// fh64_pkg: constants, widths and mixing helpers of the fasthash64 engine.
// No dependencies; used by the interfaces, the multiplier and the top level.
package fh64_pkg;

  localparam int WORD_W  = 64;
  localparam int HALF_W  = 32;
  localparam int COUNT_W = 4;
  localparam int LEN_W   = 32;

  localparam logic [WORD_W-1:0] HASH_M  = 64'h8803_55f2_1e6d_1965;
  localparam logic [WORD_W-1:0] MIX_MUL = 64'h2127_599b_f432_5c37;
  localparam int MIX_SH1 = 23;
  localparam int MIX_SH2 = 47;
  localparam int FOLD_SH = 32;

  localparam logic [COUNT_W-1:0] FULL_COUNT = 4'd8;

  // First half of the mixer: xorshift right by 23.
  function automatic logic [WORD_W-1:0] mix_pre(input logic [WORD_W-1:0] x);
    return x ^ (x >> MIX_SH1);
  endfunction

  // Last half of the mixer: xorshift right by 47.
  function automatic logic [WORD_W-1:0] mix_post(input logic [WORD_W-1:0] x);
    return x ^ (x >> MIX_SH2);
  endfunction

  // Keep the valid low bytes; counts of 8 and above keep the whole word.
  function automatic logic [WORD_W-1:0] byte_mask(input logic [COUNT_W-1:0] cnt);
    logic [WORD_W-1:0] m;
    m = '0;
    for (int i = 0; i < WORD_W / 8; i++) begin
      if (cnt > COUNT_W'(i)) begin
        m[i*8 +: 8] = 8'hff;
      end
    end
    return m;
  endfunction

  // Fold a 64-bit hash to 32 bits as h - (h >> 32), upper half zero.
  function automatic logic [WORD_W-1:0] fold32(input logic [WORD_W-1:0] h);
    logic [HALF_W-1:0] lo;
    lo = h[HALF_W-1:0] - h[WORD_W-1:FOLD_SH];
    return {{(WORD_W-HALF_W){1'b0}}, lo};
  endfunction

endpackage

// ===== hdl/fh64_in_if.sv =====
// fh64_in_if: valid/ready channel carrying one message word item.
// Depends on fh64_pkg for field widths.
interface fh64_in_if;
  logic                              valid;
  logic                              ready;
  logic [fh64_pkg::WORD_W-1:0]       data_word;
  logic [fh64_pkg::COUNT_W-1:0]      byte_count;
  logic                              first;
  logic                              last;
  logic [fh64_pkg::WORD_W-1:0]       seed;
  logic [fh64_pkg::LEN_W-1:0]        total_length;

  modport source (output valid, data_word, byte_count, first, last, seed, total_length,
                  input ready);
  modport sink (input valid, data_word, byte_count, first, last, seed, total_length,
                output ready);
endinterface

// ===== hdl/fh64_out_if.sv =====
// fh64_out_if: valid/ready channel carrying one hash result item.
// Depends on fh64_pkg for the field width.
interface fh64_out_if;
  logic                        valid;
  logic                        ready;
  logic [fh64_pkg::WORD_W-1:0] hash_value;

  modport source (output valid, hash_value, input ready);
  modport sink (input valid, hash_value, output ready);
endinterface

// ===== hdl/fast_hash_64.sv =====
// fast_hash_64: streaming fasthash64 engine, top level with the sequencer.
// Depends on fh64_pkg, fh64_in_if, fh64_out_if and fh64_mul.
//
//   channel   | dir | handshake          | payload
//   ----------+-----+--------------------+------------------------------------------
//   in_chan   | in  | valid / ready      | data_word, byte_count, first, last, seed,
//             |     |                    | total_length
//   out_chan  | out | valid / ready      | hash_value
//   cfg       | in  | cfg_we (no stall)  | cfg_wdata = fold_to_32
//
// Every 64-bit multiply runs on the shared unit as three 32x32 partial
// products plus the hand-back. A middle word takes two multiplies, a first
// item one more, and a last item one more plus the load of the output
// register. Items that do nothing only pass through the idle state.
// Reset (rst_n low, synchronous) clears the sequencer, message flag, mode and
// output valid. A result waits in the output register while out_chan stalls;
// the next item is taken meanwhile, and only a second result waits behind it.
module fast_hash_64 (
  input  logic          clk,
  input  logic          rst_n,
  fh64_in_if.sink       in_chan,
  fh64_out_if.source    out_chan,
  input  logic          cfg_we,
  input  logic          cfg_wdata
);

  typedef enum logic [2:0] {S_IDLE, S_INIT, S_WMIX, S_HMUL, S_FMIX, S_DONE} state_t;

  state_t                         state_r, state_nxt;
  logic                           fold_r;
  logic                           in_msg_r, in_msg_nxt;
  logic                           has_word_r, has_word_nxt;
  logic                           last_r, last_nxt;
  logic [fh64_pkg::WORD_W-1:0]    h_r, h_nxt;
  logic [fh64_pkg::WORD_W-1:0]    x_r, x_nxt;
  logic [fh64_pkg::WORD_W-1:0]    seed_r, seed_nxt;
  logic [fh64_pkg::WORD_W-1:0]    res_r, res_nxt;
  logic [fh64_pkg::WORD_W-1:0]    mul_a_r, mul_a_nxt;
  logic [fh64_pkg::WORD_W-1:0]    mul_b_r, mul_b_nxt;
  logic                           mul_start_r, mul_start_nxt;
  logic                           out_valid_r, out_valid_nxt;
  logic [fh64_pkg::WORD_W-1:0]    out_data_r, out_data_nxt;

  logic                           mul_done;
  logic [fh64_pkg::WORD_W-1:0]    mul_p;
  logic [fh64_pkg::WORD_W-1:0]    in_seed;
  logic [fh64_pkg::WORD_W-1:0]    in_x;
  logic [fh64_pkg::WORD_W-1:0]    init_h;

  fh64_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (mul_start_r),
    .op_a    (mul_a_r),
    .op_b    (mul_b_r),
    .done    (mul_done),
    .product (mul_p)
  );

  // Seed is cut to 32 bits in folded mode; the word is masked and half-mixed.
  assign in_seed = fold_r ? {{(fh64_pkg::WORD_W-fh64_pkg::HALF_W){1'b0}},
                             in_chan.seed[fh64_pkg::HALF_W-1:0]}
                          : in_chan.seed;
  assign in_x   = fh64_pkg::mix_pre(in_chan.data_word & fh64_pkg::byte_mask(in_chan.byte_count));
  assign init_h = seed_r ^ mul_p;

  always_comb begin
    state_nxt     = state_r;
    in_msg_nxt    = in_msg_r;
    has_word_nxt  = has_word_r;
    last_nxt      = last_r;
    h_nxt         = h_r;
    x_nxt         = x_r;
    seed_nxt      = seed_r;
    res_nxt       = res_r;
    mul_a_nxt     = mul_a_r;
    mul_b_nxt     = mul_b_r;
    mul_start_nxt = 1'b0;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    // Drop the result once the sink takes it.
    if (out_valid_r && out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_chan.valid) begin
          x_nxt        = in_x;
          has_word_nxt = (in_chan.byte_count != '0);
          last_nxt     = in_chan.last;
          seed_nxt     = in_seed;
          if (in_chan.first) begin
            // Start a new message: h = seed ^ (length * M).
            in_msg_nxt    = !in_chan.last;
            mul_a_nxt     = {{(fh64_pkg::WORD_W-fh64_pkg::LEN_W){1'b0}},
                             in_chan.total_length};
            mul_b_nxt     = fh64_pkg::HASH_M;
            mul_start_nxt = 1'b1;
            state_nxt     = S_INIT;
          end else if (in_msg_r) begin
            in_msg_nxt = !in_chan.last;
            if (in_chan.byte_count != '0) begin
              mul_a_nxt     = in_x;
              mul_b_nxt     = fh64_pkg::MIX_MUL;
              mul_start_nxt = 1'b1;
              state_nxt     = S_WMIX;
            end else if (in_chan.last) begin
              mul_a_nxt     = fh64_pkg::mix_pre(h_r);
              mul_b_nxt     = fh64_pkg::MIX_MUL;
              mul_start_nxt = 1'b1;
              state_nxt     = S_FMIX;
            end
          end
          // Items outside a message without first are ignored.
        end
      end
      S_INIT: begin
        if (mul_done) begin
          h_nxt = init_h;
          if (has_word_r) begin
            mul_a_nxt     = x_r;
            mul_b_nxt     = fh64_pkg::MIX_MUL;
            mul_start_nxt = 1'b1;
            state_nxt     = S_WMIX;
          end else if (last_r) begin
            mul_a_nxt     = fh64_pkg::mix_pre(init_h);
            mul_b_nxt     = fh64_pkg::MIX_MUL;
            mul_start_nxt = 1'b1;
            state_nxt     = S_FMIX;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_WMIX: begin
        if (mul_done) begin
          // Fold the mixed word into the hash, then scale by M.
          mul_a_nxt     = h_r ^ fh64_pkg::mix_post(mul_p);
          mul_b_nxt     = fh64_pkg::HASH_M;
          mul_start_nxt = 1'b1;
          state_nxt     = S_HMUL;
        end
      end
      S_HMUL: begin
        if (mul_done) begin
          h_nxt = mul_p;
          if (last_r) begin
            mul_a_nxt     = fh64_pkg::mix_pre(mul_p);
            mul_b_nxt     = fh64_pkg::MIX_MUL;
            mul_start_nxt = 1'b1;
            state_nxt     = S_FMIX;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_FMIX: begin
        if (mul_done) begin
          res_nxt   = fold_r ? fh64_pkg::fold32(fh64_pkg::mix_post(mul_p))
                             : fh64_pkg::mix_post(mul_p);
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        // Hold the result until the output register frees up.
        if (!out_valid_r || out_chan.ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_msg_r    <= 1'b0;
      fold_r      <= 1'b0;
      mul_start_r <= 1'b0;
      out_valid_r <= 1'b0;
      h_r         <= '0;
    end else begin
      state_r     <= state_nxt;
      in_msg_r    <= in_msg_nxt;
      mul_start_r <= mul_start_nxt;
      out_valid_r <= out_valid_nxt;
      h_r         <= h_nxt;
      if (cfg_we) begin
        fold_r <= cfg_wdata;
      end
    end
    has_word_r <= has_word_nxt;
    last_r     <= last_nxt;
    x_r        <= x_nxt;
    seed_r     <= seed_nxt;
    res_r      <= res_nxt;
    mul_a_r    <= mul_a_nxt;
    mul_b_r    <= mul_b_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_chan.ready       = (state_r == S_IDLE);
  assign out_chan.valid      = out_valid_r;
  assign out_chan.hash_value = out_data_r;

`ifndef SYNTHESIS
  // The multiplier hands back a product for each start.
  a_mul_latency: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start_r |-> ##3 mul_done)
    else $error("multiplier done not three cycles after start");

  // A product only arrives while the sequencer waits on one.
  a_done_in_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_done |-> (state_r == S_INIT || state_r == S_WMIX ||
                  state_r == S_HMUL || state_r == S_FMIX))
    else $error("multiplier done outside a multiply state");

  // A new result is loaded only from the result-wait state.
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("output loaded outside the result-wait state");

  // Start never repeats before the running multiply finishes.
  a_start_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    mul_start_r |=> !mul_start_r)
    else $error("multiplier restarted while busy");
`endif

endmodule

// ===== hdl/fh64_mul.sv =====
// fh64_mul: 64x64 -> low 64 bit multiplier built on one 32x32 multiplier,
// three partial products taken in turn. Depends on fh64_pkg.
module fh64_mul (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [fh64_pkg::WORD_W-1:0] op_a,
  input  logic [fh64_pkg::WORD_W-1:0] op_b,
  output logic                        done,
  output logic [fh64_pkg::WORD_W-1:0] product
);

  typedef enum logic [1:0] {STEP_LO, STEP_CROSS_A, STEP_CROSS_B} step_t;

  step_t                          step_r, step_nxt;
  logic                           run_r, run_nxt;
  logic                           done_r, done_nxt;
  logic [fh64_pkg::WORD_W-1:0]    acc_r, acc_nxt;

  step_t                          step_cur;
  logic [fh64_pkg::HALF_W-1:0]    mul_x, mul_y;
  logic [fh64_pkg::WORD_W-1:0]    pp;

  // Operands stay stable from start until done.
  assign step_cur = run_r ? step_r : STEP_LO;
  assign mul_x = (step_cur == STEP_CROSS_B) ? op_a[fh64_pkg::WORD_W-1:fh64_pkg::HALF_W]
                                            : op_a[fh64_pkg::HALF_W-1:0];
  assign mul_y = (step_cur == STEP_CROSS_A) ? op_b[fh64_pkg::WORD_W-1:fh64_pkg::HALF_W]
                                            : op_b[fh64_pkg::HALF_W-1:0];
  assign pp = mul_x * mul_y;

  always_comb begin
    step_nxt = step_r;
    run_nxt  = run_r;
    done_nxt = 1'b0;
    acc_nxt  = acc_r;
    if (run_r) begin
      // Cross products only reach the upper half.
      acc_nxt = acc_r + {pp[fh64_pkg::HALF_W-1:0], {fh64_pkg::HALF_W{1'b0}}};
      unique case (step_r)
        STEP_CROSS_A: step_nxt = STEP_CROSS_B;
        STEP_CROSS_B: begin
          run_nxt  = 1'b0;
          done_nxt = 1'b1;
          step_nxt = STEP_LO;
        end
        default: step_nxt = STEP_LO;
      endcase
    end else if (start) begin
      acc_nxt  = pp;
      run_nxt  = 1'b1;
      step_nxt = STEP_CROSS_A;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_LO;
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      run_r  <= run_nxt;
      done_r <= done_nxt;
    end
    acc_r <= acc_nxt;
  end

  assign done    = done_r;
  assign product = acc_r;

endmodule

// ===== tb/fast_hash_64_test.sv =====
// fast_hash_64_test: self-checking bench for the streaming fasthash64 engine.
// Needs fh64_pkg, fh64_in_if, fh64_out_if, the fast_hash_64 RTL and fh64_mul.
// Walks a directed table, then random messages, checking each hash in order.
module fast_hash_64_test;
  import fh64_pkg::*;

  localparam bit MODE_64 = 1'b0;  // fold_to_32 clear: full 64-bit hash
  localparam bit MODE_32 = 1'b1;  // fold_to_32 set: folded 32-bit hash

  localparam logic [WORD_W-1:0] ALL_ONES = '1;

  localparam int RANDOM_WORDS  = 1350;
  localparam int HOLD_CYCLES   = 400;     // long receiver hold-off
  localparam int SETTLE_CYCLES = 32;      // room for the slowest item to finish in the block
  localparam int DRAIN_LIMIT   = 5000;
  localparam int CYCLE_LIMIT   = 1500000;

  // One item on the input channel.
  typedef struct packed {
    logic [WORD_W-1:0]  data_word;
    logic [COUNT_W-1:0] byte_count;
    logic               first;
    logic               last;
    logic [WORD_W-1:0]  seed;
    logic [LEN_W-1:0]   total_length;
  } hash_word_t;

  // One row of the directed table: the mode to run it in, the item, and a
  // hash typed in by hand where it is obvious (zero seed, zero length).
  typedef struct packed {
    bit                 mode;
    logic [WORD_W-1:0]  data_word;
    logic [COUNT_W-1:0] byte_count;
    logic               first;
    logic               last;
    logic [WORD_W-1:0]  seed;
    logic [LEN_W-1:0]   total_length;
    bit                 typed;
    logic [WORD_W-1:0]  typed_hash;
  } hash_row_t;

  localparam int DIRECTED_N = 20;

  localparam hash_row_t DIRECTED [DIRECTED_N] = '{
    // empty message, zero seed and length: hash of zero is zero
    '{MODE_64, 64'h0, 4'd0, 1'b1, 1'b1, 64'h0, 32'd0, 1'b1, 64'h0},
    // word with no start while idle: ignored even though last is set
    '{MODE_64, ALL_ONES, 4'd8, 1'b0, 1'b1, ALL_ONES, 32'd5, 1'b0, 64'h0},
    // longest length and all-ones seed on a full word
    '{MODE_64, ALL_ONES, 4'd8, 1'b1, 1'b0, ALL_ONES, 32'hffff_ffff, 1'b0, 64'h0},
    // oversized count acts as a full word
    '{MODE_64, 64'h0, 4'd15, 1'b0, 1'b0, 64'h0, 32'd0, 1'b0, 64'h0},
    // partial word in the middle of a message
    '{MODE_64, ALL_ONES, 4'd3, 1'b0, 1'b0, ALL_ONES, 32'd0, 1'b0, 64'h0},
    // empty word in the middle of a message adds nothing
    '{MODE_64, ALL_ONES, 4'd0, 1'b0, 1'b0, 64'h0, 32'd0, 1'b0, 64'h0},
    '{MODE_64, 64'h0123_4567_89ab_cdef, 4'd8, 1'b0, 1'b1, ALL_ONES, 32'd9, 1'b0, 64'h0},
    // start a message, then restart it before it ends
    '{MODE_64, 64'h8000_0000_0000_0001, 4'd8, 1'b1, 1'b0, 64'h5555_5555_5555_5555,
      32'd16, 1'b0, 64'h0},
    '{MODE_64, 64'hdead_beef_cafe_f00d, 4'd8, 1'b1, 1'b1, 64'haaaa_aaaa_aaaa_aaaa,
      32'd8, 1'b0, 64'h0},
    // one-byte and seven-byte messages: masking of the unused bytes
    '{MODE_64, ALL_ONES, 4'd1, 1'b1, 1'b1, 64'h0, 32'd1, 1'b0, 64'h0},
    '{MODE_64, ALL_ONES, 4'd7, 1'b1, 1'b1, 64'h7, 32'd7, 1'b0, 64'h0},
    // length that does not match the bytes sent, with count 9
    '{MODE_64, 64'h0, 4'd9, 1'b1, 1'b1, 64'h0, 32'd100, 1'b0, 64'h0},
    // start in 64-bit mode, end in 32-bit mode: fold taken at the end
    '{MODE_64, 64'hfedc_ba98_7654_3210, 4'd8, 1'b1, 1'b0, ALL_ONES, 32'd12, 1'b0, 64'h0},
    '{MODE_32, 64'h1234_5678_9abc_def0, 4'd4, 1'b0, 1'b1, 64'h0, 32'd0, 1'b0, 64'h0},
    // upper seed bits are dropped in 32-bit mode, so this hashes to zero
    '{MODE_32, 64'h0, 4'd0, 1'b1, 1'b1, 64'hffff_ffff_0000_0000, 32'd0, 1'b1, 64'h0},
    // start in 32-bit mode (cut seed), end in 64-bit mode (no fold)
    '{MODE_32, ALL_ONES, 4'd8, 1'b1, 1'b0, ALL_ONES, 32'hffff_ffff, 1'b0, 64'h0},
    '{MODE_32, ALL_ONES, 4'd8, 1'b0, 1'b0, 64'h0, 32'd0, 1'b0, 64'h0},
    '{MODE_64, ALL_ONES, 4'd2, 1'b0, 1'b1, 64'h0, 32'd0, 1'b0, 64'h0},
    '{MODE_64, ALL_ONES, 4'd8, 1'b0, 1'b0, ALL_ONES, 32'd3, 1'b0, 64'h0},
    '{MODE_32, 64'h8000_0000_0000_0000, 4'd8, 1'b1, 1'b1, ALL_ONES, 32'd8, 1'b0, 64'h0}
  };

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic cfg_wdata;

  fh64_in_if  in_chan ();
  fh64_out_if out_chan ();

  fast_hash_64 dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_chan   (in_chan),
    .out_chan  (out_chan),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Hash predictor state: its own copy of the mode and the running hash.
  bit                fold_mode = MODE_64;
  bit                msg_open  = 1'b0;
  logic [WORD_W-1:0] hash_acc  = '0;

  logic [WORD_W-1:0] expected_hashes [$];

  int  mismatch_count = 0;
  int  hashed_words   = 0;
  int  cycle_count    = 0;
  bit  sender_steady  = 1'b0;
  bit  hold_request   = 1'b0;

  // xorshift 23, multiply, xorshift 47
  function automatic logic [WORD_W-1:0] scramble(input logic [WORD_W-1:0] x);
    x = x ^ (x >> MIX_SH1);
    x = x * MIX_MUL;
    x = x ^ (x >> MIX_SH2);
    return x;
  endfunction

  // Advance the running hash by one accepted item; return 1 with the hash
  // when the item ends a message.
  function automatic bit predict_hash(input hash_word_t w, output logic [WORD_W-1:0] hash_out);
    logic [WORD_W-1:0]  word;
    logic [WORD_W-1:0]  start_seed;
    logic [WORD_W-1:0]  h;
    logic [COUNT_W-1:0] n;
    word     = w.data_word;
    n        = w.byte_count;
    hash_out = '0;
    if (w.first) begin
      start_seed = (fold_mode == MODE_32) ? {32'b0, w.seed[31:0]} : w.seed;
      hash_acc   = start_seed ^ (WORD_W'(w.total_length) * HASH_M);
      msg_open   = 1'b1;
    end else if (!msg_open) begin
      return 1'b0;
    end
    if (n > FULL_COUNT) n = FULL_COUNT;
    if (n != 0) begin
      // clear the bytes past the count
      if (n < FULL_COUNT) word = word & ((64'd1 << (8 * n)) - 64'd1);
      hash_acc = (hash_acc ^ scramble(word)) * HASH_M;
    end
    if (!w.last) return 1'b0;
    h = scramble(hash_acc);
    if (fold_mode == MODE_32) h = {32'b0, h[31:0] - h[63:FOLD_SH]};
    hash_out = h;
    msg_open = 1'b0;
    return 1'b1;
  endfunction

  // Mostly no gap, some short ones, a few long ones.
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 15);
    return $urandom_range(30, 90);
  endfunction

  // Random word with the extremes thrown in now and then.
  function automatic logic [WORD_W-1:0] random_data();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return ALL_ONES;
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(input string what);
    $display("hash check at cycle %0d: %s", cycle_count, what);
    mismatch_count++;
  endtask

  // Offer one item, wait for the handshake, then predict and idle a while.
  task automatic feed(input hash_word_t w, input bit typed,
                      input logic [WORD_W-1:0] typed_hash);
    logic [WORD_W-1:0] predicted;
    int                gap;
    in_chan.valid        <= 1'b1;
    in_chan.data_word    <= w.data_word;
    in_chan.byte_count   <= w.byte_count;
    in_chan.first        <= w.first;
    in_chan.last         <= w.last;
    in_chan.seed         <= w.seed;
    in_chan.total_length <= w.total_length;
    do @(posedge clk); while (in_chan.ready !== 1'b1);
    // count only items the block actually hashes
    if (w.first || msg_open) hashed_words++;
    if (predict_hash(w, predicted)) begin
      expected_hashes.push_back(typed ? typed_hash : predicted);
    end
    gap = sender_steady ? 0 : gap_cycles();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Wait for every expected hash, then let an item with no result finish.
  task automatic settle();
    int waited;
    waited = 0;
    while (expected_hashes.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    if (expected_hashes.size() != 0) begin
      report_mismatch($sformatf("%0d hash results never arrived", expected_hashes.size()));
      expected_hashes.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write fold_to_32 once the block has gone quiet.
  task automatic retune(input bit mode);
    in_chan.valid <= 1'b0;
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
    fold_mode = mode;
  endtask

  // Check each hash that leaves the block against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
      if (expected_hashes.size() == 0) begin
        report_mismatch($sformatf("unexpected hash_value %h", out_chan.hash_value));
      end else begin
        if (out_chan.hash_value !== expected_hashes[0]) begin
          report_mismatch($sformatf("hash_value %h, expected %h",
                                    out_chan.hash_value, expected_hashes[0]));
        end
        void'(expected_hashes.pop_front());
      end
    end
  end

  // Receiver: random stalls, calm stretches, and a long hold-off on request
  // so that the result register and the input side back up.
  initial begin
    int stall_left;
    int phase_left;
    bit steady;
    stall_left = 0;
    phase_left = 0;
    steady     = 1'b0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (phase_left == 0) begin
        steady     = ($urandom_range(0, 3) == 0);
        phase_left = $urandom_range(50, 200);
      end
      phase_left--;
      if (hold_request) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        out_chan.ready <= 1'b1;
      end else if (stall_left > 0) begin
        out_chan.ready <= 1'b0;
        stall_left--;
      end else begin
        out_chan.ready <= 1'b1;
        if (!steady && $urandom_range(0, 3) == 0) stall_left = gap_cycles();
      end
    end
  end

  // Watchdog: drop the run if it hangs.
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("FAILURE");
    $finish;
  end

  // Stimulus: reset, directed table, then random messages and noise.
  initial begin
    hash_word_t w;
    int         kind;
    int         pick;
    int         msg_len;
    int         n_words;
    int         n_sent;
    int         remain;
    bit         cut_short;
    bit         second_hold;
    logic [WORD_W-1:0] msg_seed;
    logic [LEN_W-1:0]  msg_total;

    second_hold = 1'b0;
    rst_n                <= 1'b0;
    cfg_we               <= 1'b0;
    cfg_wdata            <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.data_word    <= '0;
    in_chan.byte_count   <= '0;
    in_chan.first        <= 1'b0;
    in_chan.last         <= 1'b0;
    in_chan.seed         <= '0;
    in_chan.total_length <= '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    retune(MODE_64);

    // Walk the directed table; switch mode only where a row asks for it.
    for (int k = 0; k < DIRECTED_N; k++) begin
      if (DIRECTED[k].mode != fold_mode) retune(DIRECTED[k].mode);
      w.data_word    = DIRECTED[k].data_word;
      w.byte_count   = DIRECTED[k].byte_count;
      w.first        = DIRECTED[k].first;
      w.last         = DIRECTED[k].last;
      w.seed         = DIRECTED[k].seed;
      w.total_length = DIRECTED[k].total_length;
      feed(w, DIRECTED[k].typed, DIRECTED[k].typed_hash);
    end

    // Hold off the receiver right away while items keep coming.
    hold_request = 1'b1;

    while (hashed_words < RANDOM_WORDS) begin
      if (!second_hold && hashed_words >= RANDOM_WORDS / 2) begin
        hold_request = 1'b1;
        second_hold  = 1'b1;
      end
      if ($urandom_range(0, 39) == 0) retune(bit'($urandom_range(0, 1)));
      sender_steady = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        // noise: any count, any flags
        w.data_word    = random_data();
        w.byte_count   = COUNT_W'($urandom_range(0, 15));
        w.first        = 1'($urandom_range(0, 1));
        w.last         = 1'($urandom_range(0, 1));
        w.seed         = random_data();
        w.total_length = $urandom;
        feed(w, 1'b0, '0);
      end else begin
        // a message, now and then cut short before its last word
        pick = $urandom_range(0, 99);
        if (pick < 10)      msg_len = 0;
        else if (pick < 70) msg_len = $urandom_range(1, 24);
        else if (pick < 96) msg_len = $urandom_range(25, 80);
        else                msg_len = $urandom_range(81, 400);
        n_words   = (msg_len == 0) ? 1 : (msg_len + 7) / 8;
        cut_short = (kind < 20);
        n_sent    = cut_short ? $urandom_range(1, n_words) : n_words;
        msg_seed  = random_data();
        msg_total = ($urandom_range(0, 9) == 0) ? LEN_W'($urandom) : LEN_W'(msg_len);
        for (int i = 0; i < n_sent; i++) begin
          remain         = msg_len - 8 * i;
          w.data_word    = random_data();
          w.byte_count   = (remain >= 8) ? FULL_COUNT : COUNT_W'(remain);
          w.first        = (i == 0);
          w.last         = !cut_short && (i == n_words - 1);
          // seed and length on later words must be ignored
          w.seed         = (i == 0) ? msg_seed : random_data();
          w.total_length = (i == 0) ? msg_total : LEN_W'($urandom);
          pick = $urandom_range(0, 99);
          if (pick < 4 && w.byte_count == FULL_COUNT) begin
            w.byte_count = COUNT_W'($urandom_range(9, 15));
          end else if (pick < 8 && !w.last) begin
            w.byte_count = COUNT_W'($urandom_range(0, 7));
          end
          // rarely flip the mode in the middle of a message
          if (i != 0 && $urandom_range(0, 199) == 0) retune(bit'($urandom_range(0, 1)));
          feed(w, 1'b0, '0);
        end
      end
    end

    in_chan.valid <= 1'b0;
    settle();
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
